// ===== hw/rtl/cjet_pkg.sv =====
// Package for the cubic Julia escape-time unit.
// Holds shared constants, register codes, state and phase enums, and the
// command/status structs between controller and datapath. No dependencies.
package cjet_pkg;

  localparam int FRAC_BITS_DEF  = 28;
  localparam int COUNT_BITS_DEF = 12;
  localparam int DATA_BITS      = 32;
  localparam int THR_BITS       = 29;
  localparam int CFG_IDX_BITS   = 2;
  localparam int THR_FRAC_BITS  = 24;

  localparam int                          MAX_ITER_RST = 40;
  localparam logic [THR_BITS-1:0]         THR_RST      = 29'd67108864;
  localparam logic signed [DATA_BITS-1:0] COEFF_RE_RST = 32'sd269765340;
  localparam logic signed [DATA_BITS-1:0] COEFF_IM_RST = 32'sd27066822;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MAX_ITER  = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_COEFF_RE  = 2'd2,
    CFG_COEFF_IM  = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_HOLD,
    PH_SQ,
    PH_CUBE,
    PH_LIN,
    PH_SUM,
    PH_MAG
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_CUBE,
    ST_LIN,
    ST_SUM,
    ST_MAG,
    ST_CHK,
    ST_EMPTY
  } state_e;

  typedef struct packed {
    phase_e phase;
    logic   load;
    logic   advance;
    logic   emit;
    logic   force_inside;
  } cmd_t;

  typedef struct packed {
    logic escaped;
    logic last_iter;
    logic max_zero;
  } sts_t;

endpackage

// ===== hw/rtl/cjet_if.sv =====
// Handshake channel interfaces for the cubic Julia escape-time unit.
// Point channel and result channel; widths from cjet_pkg.
interface cjet_point_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [cjet_pkg::DATA_BITS-1:0]   point_re;
  logic signed [cjet_pkg::DATA_BITS-1:0]   point_im;

  modport source (output valid, output point_re, output point_im, input ready);
  modport sink   (input valid, input point_re, input point_im, output ready);
endinterface

interface cjet_result_if #(
  parameter int COUNT_BITS = cjet_pkg::COUNT_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] escape_count;
  logic                  inside_res;

  modport source (output valid, output escape_count, output inside_res, input ready);
  modport sink   (input valid, input escape_count, input inside_res, output ready);
endinterface

// ===== hw/rtl/cjet_ctrl.sv =====
// Controller for the cubic Julia escape-time unit.
// Sequences the six phases of one iteration and owns the result valid flag.
// Depends on cjet_pkg.
module cjet_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output cjet_pkg::cmd_t  cmd_o,
  input  cjet_pkg::sts_t  sts_i
);

  cjet_pkg::state_e state_q, state_d;
  logic             valid_q, valid_d;
  logic             slot_free;
  logic             finish;

  assign slot_free = !valid_q || out_ready_i;
  assign finish    = sts_i.escaped || sts_i.last_iter;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cjet_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.max_zero ? cjet_pkg::ST_EMPTY : cjet_pkg::ST_SQ;
        end
      end
      cjet_pkg::ST_SQ:   state_d = cjet_pkg::ST_CUBE;
      cjet_pkg::ST_CUBE: state_d = cjet_pkg::ST_LIN;
      cjet_pkg::ST_LIN:  state_d = cjet_pkg::ST_SUM;
      cjet_pkg::ST_SUM:  state_d = cjet_pkg::ST_MAG;
      cjet_pkg::ST_MAG:  state_d = cjet_pkg::ST_CHK;
      cjet_pkg::ST_CHK: begin
        if (!finish) begin
          state_d = cjet_pkg::ST_SQ;
        end else if (slot_free) begin
          state_d = cjet_pkg::ST_IDLE;
        end
      end
      cjet_pkg::ST_EMPTY: begin
        if (slot_free) begin
          state_d = cjet_pkg::ST_IDLE;
        end
      end
      default: state_d = cjet_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o         = 1'b0;
    cmd_o              = '0;
    cmd_o.phase        = cjet_pkg::PH_HOLD;
    unique case (state_q)
      cjet_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      cjet_pkg::ST_SQ:   cmd_o.phase = cjet_pkg::PH_SQ;
      cjet_pkg::ST_CUBE: cmd_o.phase = cjet_pkg::PH_CUBE;
      cjet_pkg::ST_LIN:  cmd_o.phase = cjet_pkg::PH_LIN;
      cjet_pkg::ST_SUM:  cmd_o.phase = cjet_pkg::PH_SUM;
      cjet_pkg::ST_MAG:  cmd_o.phase = cjet_pkg::PH_MAG;
      cjet_pkg::ST_CHK: begin
        cmd_o.advance = !finish;
        cmd_o.emit    = finish && slot_free;
      end
      cjet_pkg::ST_EMPTY: begin
        cmd_o.emit         = slot_free;
        cmd_o.force_inside = 1'b1;
      end
      default: cmd_o.phase = cjet_pkg::PH_HOLD;
    endcase
  end

  assign valid_d     = cmd_o.emit || (valid_q && !out_ready_i);
  assign out_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cjet_pkg::ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

endmodule

// ===== hw/rtl/cjet_dp.sv =====
// Datapath for the cubic Julia escape-time unit.
// Config registers, four registered multiplier lanes, sum and escape check,
// iteration counter and result registers. Depends on cjet_pkg.
module cjet_dp #(
  parameter int FRAC_BITS  = cjet_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = cjet_pkg::COUNT_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [cjet_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [cjet_pkg::DATA_BITS-1:0]        cfg_wdata_i,
  input  logic signed [cjet_pkg::DATA_BITS-1:0] point_re_i,
  input  logic signed [cjet_pkg::DATA_BITS-1:0] point_im_i,
  input  cjet_pkg::cmd_t                        cmd_i,
  output cjet_pkg::sts_t                        sts_o,
  output logic [COUNT_BITS-1:0]                 escape_count_o,
  output logic                                  inside_res_o
);

  localparam int DB  = cjet_pkg::DATA_BITS;
  localparam int W   = (FRAC_BITS + 4 > DB) ? FRAC_BITS + 4 : DB;
  localparam int XW  = 2 * W - FRAC_BITS;
  localparam int PW  = XW + W;
  localparam int QW  = PW - FRAC_BITS;
  localparam int SW  = QW + 1;
  localparam int MW  = FRAC_BITS + 7;
  localparam int TB  = cjet_pkg::THR_BITS;
  localparam int TF  = cjet_pkg::THR_FRAC_BITS;
  localparam int NL  = 4;
  localparam logic signed [SW-1:0] LIM_POS = SW'(1) <<< (FRAC_BITS + 3);
  localparam logic signed [SW-1:0] LIM_NEG = -LIM_POS;

  logic [COUNT_BITS-1:0]  max_it_q;
  logic [TB-1:0]          thr_q;
  logic signed [DB-1:0]   cre_q;
  logic signed [DB-1:0]   cim_q;

  logic signed [W-1:0]    x_q, y_q;
  logic [COUNT_BITS-1:0]  cnt_q;
  logic signed [QW-1:0]   p_q [NL];
  logic signed [SW-1:0]   lin_q, re_q, ima_q, im_q;
  logic                   big_q;
  logic [COUNT_BITS-1:0]  esc_cnt_q;
  logic                   inside_q;

  logic signed [XW-1:0]   a_op [NL];
  logic signed [W-1:0]    b_op [NL];
  logic signed [PW-1:0]   prod [NL];
  logic signed [XW-1:0]   xx, yy, cre_x, cim_x;
  logic signed [W-1:0]    nr, ni;
  logic [MW-1:0]          mag;
  logic [MW-1:0]          limit;
  logic                   small_re, small_im;
  logic                   escaped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_it_q <= COUNT_BITS'(cjet_pkg::MAX_ITER_RST);
      thr_q    <= cjet_pkg::THR_RST;
      cre_q    <= cjet_pkg::COEFF_RE_RST;
      cim_q    <= cjet_pkg::COEFF_IM_RST;
    end else if (cfg_we_i) begin
      unique case (cjet_pkg::cfg_reg_e'(cfg_index_i))
        cjet_pkg::CFG_MAX_ITER:  max_it_q <= cfg_wdata_i[COUNT_BITS-1:0];
        cjet_pkg::CFG_THRESHOLD: thr_q    <= cfg_wdata_i[TB-1:0];
        cjet_pkg::CFG_COEFF_RE:  cre_q    <= $signed(cfg_wdata_i);
        cjet_pkg::CFG_COEFF_IM:  cim_q    <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  assign xx    = XW'(p_q[0]);
  assign yy    = XW'(p_q[1]);
  assign cre_x = XW'(cre_q);
  assign cim_x = XW'(cim_q);
  assign nr    = W'(re_q);
  assign ni    = W'(im_q);

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      a_op[i] = XW'(x_q);
      b_op[i] = x_q;
    end
    case (cmd_i.phase)
      cjet_pkg::PH_SQ: begin
        a_op[0] = XW'(x_q); b_op[0] = x_q;
        a_op[1] = XW'(y_q); b_op[1] = y_q;
        a_op[2] = cre_x;    b_op[2] = x_q;
        a_op[3] = cim_x;    b_op[3] = y_q;
      end
      cjet_pkg::PH_CUBE: begin
        a_op[0] = xx; b_op[0] = x_q;
        a_op[1] = yy; b_op[1] = x_q;
        a_op[2] = xx; b_op[2] = y_q;
        a_op[3] = yy; b_op[3] = y_q;
      end
      cjet_pkg::PH_LIN: begin
        a_op[0] = cre_x; b_op[0] = y_q;
        a_op[1] = cim_x; b_op[1] = x_q;
        a_op[2] = cre_x; b_op[2] = y_q;
        a_op[3] = cim_x; b_op[3] = x_q;
      end
      cjet_pkg::PH_MAG: begin
        a_op[0] = XW'(nr); b_op[0] = nr;
        a_op[1] = XW'(ni); b_op[1] = ni;
        a_op[2] = XW'(nr); b_op[2] = nr;
        a_op[3] = XW'(ni); b_op[3] = ni;
      end
      default: ;
    endcase
    for (int i = 0; i < NL; i++) begin
      prod[i] = PW'(a_op[i]) * PW'(b_op[i]);
    end
  end

  assign small_re = (re_q > LIM_NEG) && (re_q < LIM_POS);
  assign small_im = (im_q > LIM_NEG) && (im_q < LIM_POS);

  generate
    if (FRAC_BITS >= TF) begin : g_lim_up
      localparam int UP = FRAC_BITS - TF;
      assign limit = MW'(thr_q) << UP;
    end else begin : g_lim_dn
      localparam int DN = TF - FRAC_BITS;
      logic [TB:0] thr_up;
      assign thr_up = {1'b0, thr_q} + (TB + 1)'((1 << DN) - 1);
      assign limit  = MW'(thr_up >> DN);
    end
  endgenerate

  assign mag     = p_q[0][MW-1:0] + p_q[1][MW-1:0];
  assign escaped = big_q || (mag >= limit);

  assign sts_o.escaped   = escaped;
  assign sts_o.last_iter = ({1'b0, cnt_q} + (COUNT_BITS + 1)'(1)) == {1'b0, max_it_q};
  assign sts_o.max_zero  = (max_it_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= W'(point_re_i);
      y_q   <= W'(point_im_i);
      cnt_q <= '0;
    end else if (cmd_i.advance) begin
      x_q   <= nr;
      y_q   <= ni;
      cnt_q <= cnt_q + COUNT_BITS'(1);
    end

    case (cmd_i.phase)
      cjet_pkg::PH_SQ, cjet_pkg::PH_LIN, cjet_pkg::PH_MAG: begin
        for (int i = 0; i < NL; i++) begin
          p_q[i] <= prod[i][PW-1:FRAC_BITS];
        end
      end
      cjet_pkg::PH_CUBE: begin
        for (int i = 0; i < NL; i++) begin
          p_q[i] <= prod[i][PW-1:FRAC_BITS];
        end
        lin_q <= SW'(p_q[2]) - SW'(p_q[3]);
      end
      default: ;
    endcase

    if (cmd_i.phase == cjet_pkg::PH_LIN) begin
      re_q  <= SW'(p_q[0]) - SW'(p_q[1]) - (SW'(p_q[1]) <<< 1) + lin_q;
      ima_q <= SW'(p_q[2]) + (SW'(p_q[2]) <<< 1) - SW'(p_q[3]);
    end
    if (cmd_i.phase == cjet_pkg::PH_SUM) begin
      im_q <= ima_q + SW'(p_q[0]) + SW'(p_q[1]);
    end
    if (cmd_i.phase == cjet_pkg::PH_MAG) begin
      big_q <= !small_re || !small_im;
    end

    if (cmd_i.emit) begin
      esc_cnt_q <= (cmd_i.force_inside || !escaped) ? '0 : cnt_q;
      inside_q  <= cmd_i.force_inside || !escaped;
    end
  end

  assign escape_count_o = esc_cnt_q;
  assign inside_res_o   = inside_q;

endmodule

// ===== hw/rtl/cubic_julia_escape_time_unit.sv =====
// Cubic Julia escape-time unit, usage:
// Points enter on pt_i (valid/ready, signed Q4.28 real and imaginary part);
// one result per point leaves on res_o (escape index and inside flag).
// Registers are written through cfg_we_i/cfg_index_i/cfg_wdata_i while idle:
// 0 max iterations, 1 escape threshold (unsigned Q5.24), 2/3 real/imaginary part of a.
// Each iteration of z := z^3 + a*z runs through the states SQ, CUBE, LIN, SUM,
// MAG and CHK; the four shared multiplier lanes are used in four of those phases.
// An item's result is handed to the output register from CHK once it escapes or
// reaches max iterations; with max iterations zero it goes via EMPTY as inside.
// A new point is taken the cycle after the previous result is handed to the
// output register, so the unit takes no new point while one is iterating.
// If the receiver stalls, the result holds in the output register; the next
// point is still taken and iterated, and waits at its end until the output
// register frees up.
// Reset clears the controller and output valid and loads the register
// defaults (40 iterations, threshold 4.0, a = 1.00495 + 0.10083i).
// Depends on cjet_pkg, cjet_if, cjet_ctrl and cjet_dp.
module cubic_julia_escape_time_unit #(
  parameter int FRAC_BITS  = cjet_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = cjet_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cjet_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [cjet_pkg::DATA_BITS-1:0]    cfg_wdata_i,
  cjet_point_if.sink                        pt_i,
  cjet_result_if.source                     res_o
);

  cjet_pkg::cmd_t        cmd;
  cjet_pkg::sts_t        sts;
  logic [COUNT_BITS-1:0] esc_cnt;

  cjet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pt_i.valid),
    .in_ready_o  (pt_i.ready),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  cjet_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .point_re_i     (pt_i.point_re),
    .point_im_i     (pt_i.point_im),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .escape_count_o (esc_cnt),
    .inside_res_o   (res_o.inside_res)
  );

  assign res_o.escape_count = esc_cnt;

endmodule
